>>> rtl/core/hashed_key_value_table_macros.svh
// Assertion helpers shared by the RTL of the hashed key-value table.
// Every check samples on the rising clock edge and is off while reset is asserted.
`ifndef HASHED_KEY_VALUE_TABLE_MACROS_SVH
`define HASHED_KEY_VALUE_TABLE_MACROS_SVH

// Checks a property in every cycle outside reset.
`define HKV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define HKV_ASSERT_NEXT(label, trig, cons, msg) \
	`HKV_ASSERT(label, (trig) |=> (cons), msg)

`endif

>>> rtl/core/hkv_pkg.sv
package hkv_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 9;

	// Golden-ratio multiplier of the bucket hash.
	localparam logic [31:0] HASH_MULT = 32'h61C8_8647;

	// Request action codes.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;

	// Response status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_LOOKUP,
		OP_DELETE,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             was_update;
		logic [VAL_W-1:0] value_out;
		logic [CNT_W-1:0] entry_count;
	} rsp_beat_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cmd_t;

endpackage

>>> rtl/core/hashed_key_value_table.sv
// Channel   Handshake         Beat type             Direction
// req       push / full       hkv_pkg::req_beat_t   in  (action, key, value)
// rsp       pop / empty       hkv_pkg::rsp_beat_t   out (status, was_update, value_out,
//                                                        entry_count)
//
// A request leaves the command queue once the back end is idle and the response queue has
// room, while its bucket row is read into registers; in the execute state its ways are
// searched and the row and entry count written back, and the result is pushed into the
// response queue. No request is taken while one executes. After reset the valid bits are
// swept clear, one bucket row a cycle, with full held high. Both sides stall on their own:
// the command queue keeps taking requests while results wait in the response queue.
module hashed_key_value_table #(
	parameter int BUCKETS  = 64,
	parameter int WAYS     = 4,
	parameter int KEY_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  hkv_pkg::req_beat_t req,
	output logic               empty,
	input  logic               pop,
	output hkv_pkg::rsp_beat_t rsp
);

	localparam int BW  = $clog2(BUCKETS);
	localparam int CMW = $bits(hkv_pkg::cmd_t) + BW;
	localparam int RSW = $bits(hkv_pkg::rsp_beat_t);

	hkv_pkg::cmd_t      fr_cmd;
	logic [BW-1:0]      fr_bkt;
	logic               cq_full;
	logic               cq_empty;
	logic               cq_pop;
	logic [CMW-1:0]     cq_rdata;
	hkv_pkg::cmd_t      bk_cmd;
	logic [BW-1:0]      bk_bkt;
	logic               rq_full;
	logic               rq_push;
	hkv_pkg::rsp_beat_t bk_res;
	logic [RSW-1:0]     rq_rdata;
	logic               clearing;

	// The front end hashes the key and turns the action code into an operation.
	hkv_front #(
		.BUCKETS  (BUCKETS),
		.KEY_BITS (KEY_BITS)
	) u_front (
		.req (req),
		.cmd (fr_cmd),
		.bkt (fr_bkt)
	);

	// Requests are refused while the valid bits are still being cleared.
	assign full = cq_full || clearing;

	hkv_fifo #(
		.W     (CMW),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !clearing),
		.wdata  ({fr_bkt, fr_cmd}),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_rdata),
		.empty  (cq_empty)
	);

	assign bk_cmd = hkv_pkg::cmd_t'(cq_rdata[$bits(hkv_pkg::cmd_t)-1:0]);
	assign bk_bkt = cq_rdata[CMW-1 -: BW];

	// The back end owns the bucket memories and the entry count.
	hkv_back #(
		.BUCKETS  (BUCKETS),
		.WAYS     (WAYS),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (bk_cmd),
		.cmd_bkt   (bk_bkt),
		.cmd_empty (cq_empty),
		.cmd_pop   (cq_pop),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res       (bk_res),
		.clearing  (clearing)
	);

	// Finished results wait here until the consumer pops them.
	hkv_fifo #(
		.W     (RSW),
		.DEPTH (2)
	) u_rsp_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (bk_res),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign rsp = hkv_pkg::rsp_beat_t'(rq_rdata);

endmodule

>>> rtl/core/hkv_fifo.sv
module hkv_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/hkv_front.sv
module hkv_front #(
	parameter int BUCKETS  = 64,
	parameter int KEY_BITS = 32,
	localparam int BW = $clog2(BUCKETS)
) (
	input  hkv_pkg::req_beat_t req,
	output hkv_pkg::cmd_t      cmd,
	output logic [BW-1:0]      bkt
);

	// Hash bits: floor(log2(BUCKETS)); buckets above a power of two stay unused.
	localparam int HB = $clog2(BUCKETS + 1) - 1;
	localparam int KW = (KEY_BITS < hkv_pkg::KEY_W) ? KEY_BITS : hkv_pkg::KEY_W;

	logic [hkv_pkg::KEY_W-1:0] key_m;
	logic [31:0]               prod;

	assign key_m = hkv_pkg::KEY_W'(req.key[KW-1:0]);
	assign prod  = key_m * hkv_pkg::HASH_MULT;
	assign bkt   = BW'(prod[31 -: HB]);

	always_comb begin
		cmd.key   = key_m;
		cmd.value = req.value;
		case (req.action)
			hkv_pkg::ACT_INSERT: cmd.op = hkv_pkg::OP_INSERT;
			hkv_pkg::ACT_LOOKUP: cmd.op = hkv_pkg::OP_LOOKUP;
			hkv_pkg::ACT_DELETE: cmd.op = hkv_pkg::OP_DELETE;
			default:             cmd.op = hkv_pkg::OP_NOP;
		endcase
	end

endmodule

>>> rtl/core/hkv_back.sv
`include "hashed_key_value_table_macros.svh"

module hkv_back #(
	parameter int BUCKETS  = 64,
	parameter int WAYS     = 4,
	parameter int KEY_BITS = 32,
	localparam int BW = $clog2(BUCKETS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hkv_pkg::cmd_t      cmd,
	input  logic [BW-1:0]      cmd_bkt,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output hkv_pkg::rsp_beat_t res,
	output logic               clearing
);

	localparam int KW = (KEY_BITS < hkv_pkg::KEY_W) ? KEY_BITS : hkv_pkg::KEY_W;
	localparam int VW = hkv_pkg::VAL_W;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	// Bucket rows: valid bits, keys and values of all ways side by side.
	logic [WAYS-1:0]    vld_mem [BUCKETS];
	logic [WAYS*KW-1:0] key_mem [BUCKETS];
	logic [WAYS*VW-1:0] val_mem [BUCKETS];

	state_t                    st_q;
	logic [BW-1:0]             clr_q;
	logic [BW-1:0]             bkt_q;
	hkv_pkg::cmd_t             cmd_q;
	logic [hkv_pkg::CNT_W-1:0] cnt_q;
	logic [WAYS-1:0]           vld_row_q;
	logic [WAYS*KW-1:0]        key_row_q;
	logic [WAYS*VW-1:0]        val_row_q;

	logic [WAYS-1:0]           hit_vec;
	logic [WW-1:0]             hit_idx;
	logic [WW-1:0]             free_idx;
	logic                      any_hit;
	logic                      any_free;
	logic [WAYS-1:0]           vld_new;
	logic [WAYS*KW-1:0]        key_new;
	logic [WAYS*VW-1:0]        val_new;
	logic [hkv_pkg::CNT_W-1:0] cnt_new;
	logic                      wr_en;

	assign clearing = (st_q == S_CLEAR);
	assign cmd_pop  = (st_q == S_IDLE) && !cmd_empty && !res_full;
	assign wr_en    = (st_q == S_EXEC);
	assign res_push = wr_en;

	// Way search: lowest matching valid way and lowest free way.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = vld_row_q[w] && (key_row_q[w*KW +: KW] == cmd_q.key[KW-1:0]);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_idx = WW'(w);
			end
			if (!vld_row_q[w]) begin
				free_idx = WW'(w);
			end
		end
		any_hit  = |hit_vec;
		any_free = !(&vld_row_q);
	end

	always_comb begin
		vld_new            = vld_row_q;
		key_new            = key_row_q;
		val_new            = val_row_q;
		cnt_new            = cnt_q;
		res.status         = hkv_pkg::ST_NOT_FOUND;
		res.was_update     = 1'b0;
		res.value_out      = '0;
		case (cmd_q.op)
			hkv_pkg::OP_INSERT: begin
				if (any_hit) begin
					val_new[hit_idx*VW +: VW] = cmd_q.value;
					res.status                = hkv_pkg::ST_OK;
					res.was_update            = 1'b1;
				end else if (any_free) begin
					vld_new[free_idx]          = 1'b1;
					key_new[free_idx*KW +: KW] = cmd_q.key[KW-1:0];
					val_new[free_idx*VW +: VW] = cmd_q.value;
					cnt_new                    = cnt_q + 1'b1;
					res.status                 = hkv_pkg::ST_OK;
				end else begin
					res.status = hkv_pkg::ST_FULL;
				end
			end
			hkv_pkg::OP_LOOKUP, hkv_pkg::OP_DELETE: begin
				if (any_hit) begin
					res.value_out = val_row_q[hit_idx*VW +: VW];
					res.status    = hkv_pkg::ST_OK;
					if (cmd_q.op == hkv_pkg::OP_DELETE) begin
						vld_new[hit_idx] = 1'b0;
						cnt_new          = cnt_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		res.entry_count = cnt_new;
	end

	// Row read, registered.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			vld_row_q <= vld_mem[cmd_bkt];
			key_row_q <= key_mem[cmd_bkt];
			val_row_q <= val_mem[cmd_bkt];
		end
	end

	// Row write-back, and the clearing sweep of the valid bits after reset.
	always_ff @(posedge clk) begin
		if (st_q == S_CLEAR) begin
			vld_mem[clr_q] <= '0;
		end else if (wr_en) begin
			vld_mem[bkt_q] <= vld_new;
		end
		if (wr_en) begin
			key_mem[bkt_q] <= key_new;
			val_mem[bkt_q] <= val_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLEAR;
			clr_q <= '0;
			bkt_q <= '0;
			cmd_q <= '0;
			cnt_q <= '0;
		end else begin
			case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_pop) begin
						cmd_q <= cmd;
						bkt_q <= cmd_bkt;
						st_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					cnt_q <= cnt_new;
					st_q  <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	`HKV_ASSERT_NEXT(a_exec_one_cycle, st_q == S_EXEC, st_q == S_IDLE, "execute lasted over a cycle")
	`HKV_ASSERT(a_no_result_drop, !res_push || !res_full, "result written into a full queue")
	`HKV_ASSERT_NEXT(a_pop_starts_exec, cmd_pop, st_q == S_EXEC, "popped command not executed")

endmodule
